// ===== hdl/fpr_pkg.sv =====
// Shared types and constants for the FIFO page replacement unit.
package fpr_pkg;

    // Field widths and fixed constants
    localparam int ADDR_W     = 32;
    localparam int PAGE_SHIFT = 12;
    localparam int TAG_W      = ADDR_W - PAGE_SHIFT;
    localparam int CFG_W      = 7;
    localparam int CNT_W      = 32;
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic start;
        logic scan;
        logic commit;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic resolved;
    } t_status;

endpackage

// ===== hdl/fpr_ctrl.sv =====
// Sequencer for the FIFO page replacement unit: request handshakes and scan control.
module fpr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    output logic            o_valid,
    input  logic            i_ready,
    input  fpr_pkg::t_status i_status,
    output fpr_pkg::t_cmd   o_cmd
);

    fpr_pkg::t_state r_state;
    fpr_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            w_out_free;

    // The result register may be overwritten once it is empty or being taken
    assign w_out_free = !r_out_valid || i_ready;

    // Next-state logic
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fpr_pkg::ST_IDLE: begin
                if (i_valid) n_state = fpr_pkg::ST_SCAN;
            end
            fpr_pkg::ST_SCAN: begin
                if (i_status.resolved) n_state = fpr_pkg::ST_COMMIT;
            end
            fpr_pkg::ST_COMMIT: begin
                if (w_out_free) n_state = fpr_pkg::ST_IDLE;
            end
            default: n_state = fpr_pkg::ST_IDLE;
        endcase
    end

    // Output and command decoding
    always_comb begin
        o_cmd       = '0;
        o_ready     = 1'b0;
        n_out_valid = r_out_valid && !i_ready;
        unique case (r_state)
            fpr_pkg::ST_IDLE: begin
                o_ready     = 1'b1;
                o_cmd.start = i_valid;
            end
            fpr_pkg::ST_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            fpr_pkg::ST_COMMIT: begin
                if (w_out_free) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                end
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // State and result-valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fpr_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;

`ifndef SYNTHESIS
    // An accepted request always starts a scan.
    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == fpr_pkg::ST_SCAN))
        else $error("accepted request did not start a scan");

    // A new result appears only out of the commit state.
    a_result_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid || i_ready) ##1 r_out_valid |-> $past(r_state == fpr_pkg::ST_COMMIT))
        else $error("result appeared without a commit");

    // A commit never overwrites a result that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> (!r_out_valid || i_ready))
        else $error("commit while result pending");
`endif

endmodule

// ===== hdl/fpr_dp.sv =====
// Datapath for the FIFO page replacement unit: tag memory, FIFO pointers and totals.
module fpr_dp #(
    parameter int FRAMES = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [fpr_pkg::CFG_W-1:0]         i_cfg_wdata,
    input  logic [fpr_pkg::ADDR_W-1:0]        i_address,
    input  logic                              i_is_write,
    input  fpr_pkg::t_cmd                     i_cmd,
    output fpr_pkg::t_status                  o_status,
    output logic                              o_hit,
    output logic                              o_disk_read,
    output logic                              o_dirty_writeback,
    output logic [fpr_pkg::CNT_W-1:0]         o_event_total,
    output logic [fpr_pkg::CNT_W-1:0]         o_read_total,
    output logic [fpr_pkg::CNT_W-1:0]         o_write_total
);

    localparam int SW   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int OW   = $clog2(FRAMES + 1);
    localparam int SUMW = ((SW > OW) ? SW : OW) + 1;
    localparam int EW   = (OW > fpr_pkg::CFG_W) ? OW : fpr_pkg::CFG_W;
    localparam int WW   = fpr_pkg::TAG_W + 1;
    localparam logic [fpr_pkg::CNT_W-1:0] CNT_MAX = '1;

    // Tag memory: dirty bit above the 20-bit page tag
    logic [WW-1:0]               r_mem [FRAMES];
    logic [WW-1:0]               r_rdata;

    logic [fpr_pkg::CFG_W-1:0]   r_frames_cfg;
    logic [fpr_pkg::TAG_W-1:0]   r_tag;
    logic                        r_wr;
    logic [OW-1:0]               r_occ;
    logic [SW-1:0]               r_oldest;
    logic [SW-1:0]               r_ptr;
    logic [OW-1:0]               r_issue_cnt;
    logic                        r_rd_vld;
    logic                        r_rd_first;
    logic [SW-1:0]               r_rd_slot;
    logic                        r_found;
    logic [SW-1:0]               r_found_slot;
    logic                        r_old_dirty;
    logic                        r_hit;
    logic                        r_disk_read;
    logic                        r_wb;
    logic [fpr_pkg::CNT_W-1:0]   r_events;
    logic [fpr_pkg::CNT_W-1:0]   r_reads;
    logic [fpr_pkg::CNT_W-1:0]   r_writes;

    logic                        w_match;
    logic                        w_resolved;
    logic                        w_issue;
    logic [SW-1:0]               w_ptr_next;
    logic [SW-1:0]               w_oldest_next;
    logic [SUMW-1:0]             w_free_sum;
    logic [SUMW-1:0]             w_free_wrap;
    logic [SW-1:0]               w_free_slot;
    logic [EW-1:0]               w_eff;
    logic                        w_room;
    logic                        w_mem_we;
    logic [SW-1:0]               w_mem_addr;
    logic [WW-1:0]               w_mem_wdata;

    // Scan compare and completion
    assign w_match    = r_rd_vld && (r_rdata[fpr_pkg::TAG_W-1:0] == r_tag);
    assign w_resolved = w_match || ((r_issue_cnt == r_occ) && !r_rd_vld);
    assign w_issue    = i_cmd.scan && (r_issue_cnt != r_occ) && !w_resolved;
    assign o_status.resolved = w_resolved;

    // Slot pointers wrap at the frame count
    assign w_ptr_next    = (r_ptr == SW'(FRAMES - 1)) ? '0 : r_ptr + 1'b1;
    assign w_oldest_next = (r_oldest == SW'(FRAMES - 1)) ? '0 : r_oldest + 1'b1;

    // Free slot follows the newest resident page; the sum stays below twice FRAMES
    assign w_free_sum  = SUMW'(r_oldest) + SUMW'(r_occ);
    assign w_free_wrap = (w_free_sum >= SUMW'(FRAMES)) ? w_free_sum - SUMW'(FRAMES)
                                                      : w_free_sum;
    assign w_free_slot = w_free_wrap[SW-1:0];

    // Configured frame count clamped to the range one to FRAMES
    always_comb begin
        priority if (r_frames_cfg == '0) begin
            w_eff = EW'(1);
        end else if (EW'(r_frames_cfg) > EW'(FRAMES)) begin
            w_eff = EW'(FRAMES);
        end else begin
            w_eff = EW'(r_frames_cfg);
        end
    end
    assign w_room = EW'(r_occ) < w_eff;

    // Single write port of the tag memory, used only at commit
    always_comb begin
        w_mem_we    = 1'b0;
        w_mem_addr  = r_oldest;
        w_mem_wdata = {r_wr, r_tag};
        if (i_cmd.commit) begin
            priority if (r_found) begin
                w_mem_we    = r_wr;
                w_mem_addr  = r_found_slot;
                w_mem_wdata = {1'b1, r_tag};
            end else if (w_room) begin
                w_mem_we    = 1'b1;
                w_mem_addr  = w_free_slot;
            end else begin
                w_mem_we    = 1'b1;
                w_mem_addr  = r_oldest;
            end
        end
    end

    // Tag memory with registered read data
    always_ff @(posedge i_clk) begin
        if (w_mem_we) r_mem[w_mem_addr] <= w_mem_wdata;
        r_rdata <= r_mem[r_ptr];
    end

    // Control state: configuration, FIFO pointers, scan pipeline and totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_cfg <= fpr_pkg::CFG_RESET;
            r_occ        <= '0;
            r_oldest     <= '0;
            r_ptr        <= '0;
            r_issue_cnt  <= '0;
            r_rd_vld     <= 1'b0;
            r_found      <= 1'b0;
            r_events     <= '0;
            r_reads      <= '0;
            r_writes     <= '0;
        end else begin
            if (i_cfg_we) r_frames_cfg <= i_cfg_wdata;

            if (i_cmd.start) begin
                r_ptr       <= r_oldest;
                r_issue_cnt <= '0;
                r_rd_vld    <= 1'b0;
            end else begin
                r_rd_vld <= w_issue;
                if (w_issue) begin
                    r_ptr       <= w_ptr_next;
                    r_issue_cnt <= r_issue_cnt + 1'b1;
                end
            end

            if (i_cmd.scan && w_resolved) r_found <= w_match;

            if (i_cmd.commit) begin
                r_events <= (r_events == CNT_MAX) ? r_events : r_events + 1'b1;
                if (!r_found) begin
                    r_reads <= (r_reads == CNT_MAX) ? r_reads : r_reads + 1'b1;
                    if (w_room) begin
                        r_occ <= r_occ + 1'b1;
                    end else begin
                        r_oldest <= w_oldest_next;
                        if (r_old_dirty) begin
                            r_writes <= (r_writes == CNT_MAX) ? r_writes : r_writes + 1'b1;
                        end
                    end
                end
            end
        end
    end

    // Payload registers: request fields, scan tracking and result flags
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_tag <= i_address[fpr_pkg::ADDR_W-1:fpr_pkg::PAGE_SHIFT];
            r_wr  <= i_is_write;
        end
        if (w_issue) begin
            r_rd_slot  <= r_ptr;
            r_rd_first <= (r_issue_cnt == '0);
        end
        // The first slot scanned is the oldest page, the eviction candidate
        if (r_rd_vld && r_rd_first) r_old_dirty <= r_rdata[fpr_pkg::TAG_W];
        if (i_cmd.scan && w_resolved) r_found_slot <= r_rd_slot;
        if (i_cmd.commit) begin
            r_hit       <= r_found;
            r_disk_read <= !r_found;
            r_wb        <= !r_found && !w_room && r_old_dirty;
        end
    end

    assign o_hit             = r_hit;
    assign o_disk_read       = r_disk_read;
    assign o_dirty_writeback = r_wb;
    assign o_event_total     = r_events;
    assign o_read_total      = r_reads;
    assign o_write_total     = r_writes;

`ifndef SYNTHESIS
    // Residency never exceeds the physical frame count.
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OW'(FRAMES))
        else $error("occupancy above frame count");

    // The scan never reads more entries than are resident.
    a_issue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan |-> (r_issue_cnt <= r_occ))
        else $error("scan ran past resident pages");

    // The oldest pointer only moves on an eviction commit.
    a_oldest_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.commit |=> $stable(r_oldest))
        else $error("oldest pointer moved without a commit");
`endif

endmodule

// ===== hdl/fifo_page_replacement_top.sv =====
// Top level of the FIFO page replacement unit.
//
// Each request is one memory access; its page (address >> 12) is looked up
// among the resident pages by reading the tag memory one slot per cycle,
// oldest first, until the page hits or every resident slot has been read.
// A miss fills the next free frame or replaces the oldest page once the
// configured frame count is reached, counting a disk write when the victim
// was dirty. The result register lets a new request be accepted while the
// previous result waits. The frame count register may be rewritten only
// while no request is in flight.
module fifo_page_replacement_top #(
    parameter int FRAMES = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [fpr_pkg::CFG_W-1:0]  i_cfg_wdata,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [fpr_pkg::ADDR_W-1:0] i_address,
    input  logic                       i_is_write,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_hit,
    output logic                       o_disk_read,
    output logic                       o_dirty_writeback,
    output logic [fpr_pkg::CNT_W-1:0]  o_event_total,
    output logic [fpr_pkg::CNT_W-1:0]  o_read_total,
    output logic [fpr_pkg::CNT_W-1:0]  o_write_total
);

    fpr_pkg::t_cmd    w_cmd;
    fpr_pkg::t_status w_status;

    // Sequencer
    fpr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    // Tag memory, pointers and totals
    fpr_dp #(
        .FRAMES (FRAMES)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_address         (i_address),
        .i_is_write        (i_is_write),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .o_hit             (o_hit),
        .o_disk_read       (o_disk_read),
        .o_dirty_writeback (o_dirty_writeback),
        .o_event_total     (o_event_total),
        .o_read_total      (o_read_total),
        .o_write_total     (o_write_total)
    );

endmodule
